FILE: rtl/core/rlmfs_pkg.sv
// Shared types, codes and constants for the RGB LED matrix frame store.
package rlmfs_pkg;

    localparam int SIDE       = 8;
    localparam int ROW_W      = $clog2(SIDE);
    localparam int PTR_W      = 8;
    localparam int COLOUR_W   = 3;
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Input beat kinds carried in the slave-side tuser.
    localparam logic [MODE_W-1:0] MODE_MATCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd2;

    // Command byte values.
    localparam logic [BYTE_W-1:0] CMD_BYTE_ADDRESS = 8'd200;
    localparam logic [BYTE_W-1:0] CMD_BYTE_FILL_LO = 8'd240;
    localparam logic [BYTE_W-1:0] CMD_BYTE_FILL_HI = 8'd247;
    localparam logic [BYTE_W-1:0] BUS_ADDRESS_LO   = 8'd130;
    localparam logic [BYTE_W-1:0] BUS_ADDRESS_HI   = 8'd180;

    typedef enum logic [1:0] {
        CMD_IDLE    = 2'd0,
        CMD_PIXEL   = 2'd1,
        CMD_ADDRESS = 2'd2,
        CMD_FILLED  = 2'd3
    } cmd_state_t;

    // Commands from the controller to the datapath for one accepted beat.
    typedef struct packed {
        logic result;
        logic scan;
        logic fill;
        logic load_ptr;
        logic ptr_advance;
        logic pixel_store;
        logic new_address;
    } dp_cmd_t;

    typedef struct packed {
        logic ptr_in_frame;
    } dp_status_t;

    // Blue mask of the OK glyph, one row at a time.
    function automatic logic [SIDE-1:0] ok_glyph_row(input logic [ROW_W-1:0] row);
        logic [SIDE-1:0] mask;
        case (row)
            3'd0:    mask = 8'h18;
            3'd1:    mask = 8'h24;
            3'd2:    mask = 8'h24;
            3'd3:    mask = 8'h18;
            3'd4:    mask = 8'h00;
            3'd5:    mask = 8'h3C;
            3'd6:    mask = 8'h18;
            3'd7:    mask = 8'h24;
            default: mask = 8'h00;
        endcase
        return mask;
    endfunction

endpackage

FILE: rtl/core/rlmfs_ctrl.sv
// Command state machine that decodes bus beats into datapath commands.
module rlmfs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [rlmfs_pkg::MODE_W-1:0] mode,
    input  logic [rlmfs_pkg::BYTE_W-1:0] data_byte,
    input  rlmfs_pkg::dp_status_t      status,
    output rlmfs_pkg::dp_cmd_t         cmd
);
    import rlmfs_pkg::*;

    cmd_state_t state_reg;
    cmd_state_t state_next;
    logic       is_data;
    logic       fill_byte;
    logic       address_ok;

    assign is_data    = accept && (mode == MODE_DATA);
    assign fill_byte  = data_byte inside {[CMD_BYTE_FILL_LO:CMD_BYTE_FILL_HI]};
    assign address_ok = data_byte inside {[BUS_ADDRESS_LO:BUS_ADDRESS_HI]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CMD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept && (mode == MODE_MATCH))
        begin
            state_next = CMD_IDLE;
        end
        else if (is_data && (state_reg == CMD_IDLE))
        begin
            if (data_byte == CMD_BYTE_ADDRESS)
            begin
                state_next = CMD_ADDRESS;
            end
            else if (fill_byte)
            begin
                state_next = CMD_FILLED;
            end
            else
            begin
                state_next = CMD_PIXEL;
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.result = accept;
        cmd.scan   = accept && (mode == MODE_SCAN);
        if (is_data)
        begin
            case (state_reg)
                CMD_IDLE:
                begin
                    cmd.fill     = (data_byte != CMD_BYTE_ADDRESS) && fill_byte;
                    cmd.load_ptr = (data_byte != CMD_BYTE_ADDRESS) && !fill_byte;
                end
                CMD_PIXEL:
                begin
                    cmd.ptr_advance = 1'b1;
                    cmd.pixel_store = status.ptr_in_frame;
                end
                CMD_ADDRESS:
                begin
                    cmd.new_address = address_ok;
                end
                default:
                begin
                    // Bytes after a fill are ignored until the next address match.
                    cmd.new_address = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/rlmfs_datapath.sv
// Frame store, write pointer, scan row and output register.
module rlmfs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rlmfs_pkg::dp_cmd_t              cmd,
    input  logic [rlmfs_pkg::BYTE_W-1:0]    data_byte,
    input  logic                            out_ready,
    output rlmfs_pkg::dp_status_t           status,
    output logic                            in_ready,
    output logic                            out_valid,
    output logic [rlmfs_pkg::OUT_DATA_W-1:0] out_data,
    output logic [rlmfs_pkg::OUT_USER_W-1:0] out_user
);
    import rlmfs_pkg::*;

    // One column mask per row and colour.
    logic [SIDE-1:0]  red_reg   [SIDE];
    logic [SIDE-1:0]  green_reg [SIDE];
    logic [SIDE-1:0]  blue_reg  [SIDE];
    logic [PTR_W-1:0] ptr_reg;
    logic [ROW_W-1:0] scan_row_reg;

    logic             valid_reg;
    logic             row_valid_reg;
    logic             addr_valid_reg;
    logic [ROW_W-1:0] row_index_reg;
    logic [SIDE-1:0]  red_out_reg;
    logic [SIDE-1:0]  green_out_reg;
    logic [SIDE-1:0]  blue_out_reg;
    logic [BYTE_W-1:0] addr_out_reg;

    logic [ROW_W-1:0] pix_row;
    logic [ROW_W-1:0] pix_col;

    // Pointer p addresses row p mod 8 and column 7 - p/8.
    assign pix_row = ptr_reg[ROW_W-1:0];
    assign pix_col = ROW_W'(SIDE - 1) - ptr_reg[2*ROW_W-1:ROW_W];
    assign status.ptr_in_frame = (ptr_reg[PTR_W-1:2*ROW_W] == '0);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_user  = {addr_valid_reg, row_valid_reg};
    assign out_data  = {{(OUT_DATA_W - 3*SIDE - BYTE_W - ROW_W){1'b0}}, addr_out_reg,
                        blue_out_reg, green_out_reg, red_out_reg, row_index_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SIDE; r++)
            begin
                red_reg[r]   <= '0;
                green_reg[r] <= '0;
                blue_reg[r]  <= '0;
            end
            ptr_reg      <= '0;
            scan_row_reg <= '0;
        end
        else
        begin
            if (cmd.fill)
            begin
                for (int r = 0; r < SIDE; r++)
                begin
                    red_reg[r]   <= {SIDE{data_byte[2]}};
                    green_reg[r] <= {SIDE{data_byte[1]}};
                    blue_reg[r]  <= {SIDE{data_byte[0]}};
                end
            end
            else if (cmd.new_address)
            begin
                for (int r = 0; r < SIDE; r++)
                begin
                    red_reg[r]   <= '0;
                    green_reg[r] <= '0;
                    blue_reg[r]  <= ok_glyph_row(ROW_W'(r));
                end
            end
            else if (cmd.pixel_store)
            begin
                red_reg[pix_row][pix_col]   <= data_byte[2];
                green_reg[pix_row][pix_col] <= data_byte[1];
                blue_reg[pix_row][pix_col]  <= data_byte[0];
            end

            if (cmd.load_ptr)
            begin
                ptr_reg <= data_byte;
            end
            else if (cmd.ptr_advance)
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end

            if (cmd.scan)
            begin
                scan_row_reg <= scan_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload; fields that do not apply to this beat are zero.
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            row_valid_reg  <= cmd.scan;
            row_index_reg  <= cmd.scan ? scan_row_reg : '0;
            red_out_reg    <= cmd.scan ? red_reg[scan_row_reg] : '0;
            green_out_reg  <= cmd.scan ? green_reg[scan_row_reg] : '0;
            blue_out_reg   <= cmd.scan ? blue_reg[scan_row_reg] : '0;
            addr_valid_reg <= cmd.new_address;
            addr_out_reg   <= cmd.new_address ? data_byte : '0;
        end
    end

endmodule

FILE: rtl/core/rgb_led_matrix_bus_frame_store.sv
// Top level of the RGB LED matrix frame store: controller plus datapath.
//
//  Channel  Direction  Payload
//  s_*      in         tuser[1:0] mode; tdata[7:0] data_byte
//  m_*      out        tuser row_valid, store_address_valid; tdata row_index,
//                      red_columns, green_columns, blue_columns, store_address
//
// Each accepted beat yields exactly one result beat in the next cycle.
// The frame is held in flip-flops, so fills, glyph draws and pixel writes
// complete in the accepting cycle; one beat per cycle unless output stalls.
// Reset clears the frame, pointer, scan row and command state at once.
// A stalled result holds in the output register; input stalls only while
// that register is full and not being taken.
module rgb_led_matrix_bus_frame_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] data_byte
    input  logic [rlmfs_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] mode
    input  logic [rlmfs_pkg::MODE_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] row_index, [10:3] red_columns, [18:11] green_columns,
    // [26:19] blue_columns, [34:27] store_address, [39:35] zero
    output logic [rlmfs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] row_valid, [1] store_address_valid
    output logic [rlmfs_pkg::OUT_USER_W-1:0]  m_tuser
);
    import rlmfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    rlmfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_tuser),
        .data_byte (s_tdata[BYTE_W-1:0]),
        .status    (status),
        .cmd       (cmd)
    );

    rlmfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_tdata[BYTE_W-1:0]),
        .out_ready (m_tready),
        .status    (status),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

FILE: rtl/core/rlmfs_checker.sv
// Port-level checks for the RGB LED matrix frame store, bound to the top level.
module rlmfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import rlmfs_pkg::*;

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Every accepted beat produces a result beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // A result is either a scanned row or an address strobe, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("row and address result in one beat");

    // A strobed address lies in the accepted range; otherwise it reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1] ? (m_tdata[34:27] >= BUS_ADDRESS_LO &&
                                    m_tdata[34:27] <= BUS_ADDRESS_HI)
                                 : (m_tdata[34:27] == 8'd0)))
        else $error("store address out of range");

    // Row fields are zero unless the beat carries a scanned row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[26:0] == 27'd0))
        else $error("row fields set on a non-scan result");

endmodule

bind rgb_led_matrix_bus_frame_store rlmfs_checker u_rlmfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/rgb_led_matrix_bus_frame_store_checker.sv
// Scoreboard for the frame store: predicts each result beat and compares it with the output.
module rgb_led_matrix_bus_frame_store_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rlmfs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [rlmfs_pkg::MODE_W-1:0]     s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rlmfs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [rlmfs_pkg::OUT_USER_W-1:0] m_tuser,
    output int                               failures,
    output int                               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import rlmfs_pkg::*;

    typedef struct packed {
        logic              row_valid;
        logic [ROW_W-1:0]  row_index;
        logic [SIDE-1:0]   red;
        logic [SIDE-1:0]   green;
        logic [SIDE-1:0]   blue;
        logic              addr_valid;
        logic [BYTE_W-1:0] address;
    } frame_result_t;

    // Blue OK glyph, row r in bits r*8+7 down to r*8, so bit r*8+c is pixel (r, c).
    localparam logic [SIDE*SIDE-1:0] OK_GLYPH = 64'h2418_3C00_1824_2418;

    logic [COLOUR_W-1:0] frame [SIDE*SIDE];
    logic [PTR_W-1:0]    wr_ptr;
    cmd_state_t          cmd_state;
    logic [ROW_W-1:0]    scan_row;
    frame_result_t       results_due [$];

    function automatic frame_result_t frame_store_step(input logic [MODE_W-1:0] mode,
                                                       input logic [BYTE_W-1:0] b);
        frame_result_t res;
        int            p;
        res = '0;
        p   = wr_ptr;
        case (mode)
            MODE_MATCH: cmd_state = CMD_IDLE;
            MODE_DATA:
            begin
                case (cmd_state)
                    CMD_IDLE:
                    begin
                        if (b == CMD_BYTE_ADDRESS)
                            cmd_state = CMD_ADDRESS;
                        else if (b >= CMD_BYTE_FILL_LO && b <= CMD_BYTE_FILL_HI)
                        begin
                            cmd_state = CMD_FILLED;
                            foreach (frame[i]) frame[i] = b[COLOUR_W-1:0];
                        end
                        else
                        begin
                            cmd_state = CMD_PIXEL;
                            wr_ptr    = b;
                        end
                    end
                    CMD_PIXEL:
                    begin
                        // The pointer runs down the columns, right to left.
                        if (p < SIDE*SIDE)
                            frame[(p % SIDE)*SIDE + (SIDE-1 - p/SIDE)] = b[COLOUR_W-1:0];
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    CMD_ADDRESS:
                    begin
                        if (b >= BUS_ADDRESS_LO && b <= BUS_ADDRESS_HI)
                        begin
                            res.addr_valid = 1'b1;
                            res.address    = b;
                            foreach (frame[i]) frame[i] = OK_GLYPH[i] ? 3'd1 : 3'd0;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_SCAN:
            begin
                res.row_valid = 1'b1;
                res.row_index = scan_row;
                for (int c = 0; c < SIDE; c++)
                begin
                    res.red[c]   = frame[scan_row*SIDE + c][2];
                    res.green[c] = frame[scan_row*SIDE + c][1];
                    res.blue[c]  = frame[scan_row*SIDE + c][0];
                end
                scan_row = scan_row + 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    function automatic string show(input frame_result_t r);
        return $sformatf("row_valid=%0d row=%0d r=%02h g=%02h b=%02h addr_valid=%0d addr=%0d",
                         r.row_valid, r.row_index, r.red, r.green, r.blue,
                         r.addr_valid, r.address);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            foreach (frame[i]) frame[i] = '0;
            wr_ptr    = '0;
            cmd_state = CMD_IDLE;
            scan_row  = '0;
            results_due.delete();
            failures  = 0;
            pending  <= 0;
        end
        else
        begin
            // Check the outgoing beat before predicting the incoming one: a result
            // can never belong to a beat accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                got.row_valid  = m_tuser[0];
                got.addr_valid = m_tuser[1];
                got.row_index  = m_tdata[2:0];
                got.red        = m_tdata[10:3];
                got.green      = m_tdata[18:11];
                got.blue       = m_tdata[26:19];
                got.address    = m_tdata[34:27];
                if (results_due.size() == 0)
                    note_failure({"result beat with nothing expected: ", show(got)});
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want || m_tdata[39:35] !== '0)
                        note_failure($sformatf("mismatch: expected %s, got %s pad=%02h",
                                               show(want), show(got), m_tdata[39:35]));
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(frame_store_step(s_tuser, s_tdata));
            pending <= results_due.size();
        end
    end

endmodule

FILE: tb/sv/rgb_led_matrix_bus_frame_store_tb.sv
// Testbench top for the frame store: clock, reset, stimulus with random gaps and the verdict.
module rgb_led_matrix_bus_frame_store_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rlmfs_pkg::*;

    localparam int                ITEM_TARGET = 1650;
    localparam int                QUIET_TAIL  = 200;
    localparam int                CYCLE_LIMIT = 400000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int failures;
    int pending;
    int cycles = 0;
    int sent = 0;
    int stall_left = 0;
    bit gaps_on = 1'b1;

    rgb_led_matrix_bus_frame_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rgb_led_matrix_bus_frame_store_checker frame_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: ready drops in bursts of random length while gaps are allowed.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b,
                             input bit counted = 1'b1);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (counted)
            sent++;
        gaps_on = (sent < ITEM_TARGET - QUIET_TAIL) && ((sent / 150) % 4 != 3);
    endtask

    initial
    begin
        int            kind;
        int            n;
        logic [BYTE_W-1:0] b;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: scan of a cleared frame, a byte before any match, pointer at the
        // frame edge and beyond, wrap of the pointer, unused mode, fills, address change.
        send_beat(MODE_SCAN, 8'h00);
        send_beat(MODE_DATA, 8'd5);
        send_beat(MODE_DATA, 8'h07);
        send_beat(MODE_MATCH, 8'hA5);
        send_beat(MODE_DATA, 8'd63);
        send_beat(MODE_DATA, 8'd3);
        send_beat(MODE_DATA, 8'd4);
        send_beat(MODE_MATCH, 8'h00);
        send_beat(MODE_DATA, 8'd255);
        send_beat(MODE_DATA, 8'd2);
        send_beat(MODE_DATA, 8'hFF);
        send_beat(MODE_UNUSED, 8'hFF);
        send_beat(MODE_MATCH, 8'hFF);
        send_beat(MODE_DATA, CMD_BYTE_FILL_HI);
        send_beat(MODE_DATA, 8'h00);
        send_beat(MODE_SCAN, 8'hFF);
        send_beat(MODE_MATCH, 8'h5A);
        send_beat(MODE_DATA, CMD_BYTE_ADDRESS);
        send_beat(MODE_DATA, BUS_ADDRESS_LO - 8'd1);
        send_beat(MODE_DATA, BUS_ADDRESS_HI + 8'd1);
        send_beat(MODE_DATA, BUS_ADDRESS_LO);
        send_beat(MODE_DATA, BUS_ADDRESS_HI);
        send_beat(MODE_MATCH, 8'h00);
        send_beat(MODE_DATA, CMD_BYTE_FILL_LO);
        send_beat(MODE_SCAN, 8'h00);

        // Random part: mostly well-formed command sequences, plenty of scans to
        // observe the frame, and a little noise.
        while (sent < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                send_beat(MODE_MATCH, BYTE_W'($urandom_range(0, 255)));
                b = ($urandom_range(0, 3) != 0) ? BYTE_W'($urandom_range(0, SIDE*SIDE-1))
                                                : BYTE_W'($urandom_range(0, 255));
                send_beat(MODE_DATA, b);
                n = $urandom_range(1, 12);
                repeat (n) send_beat(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind < 52)
            begin
                send_beat(MODE_MATCH, BYTE_W'($urandom_range(0, 255)));
                send_beat(MODE_DATA, CMD_BYTE_FILL_LO + BYTE_W'($urandom_range(0, 7)));
                n = $urandom_range(0, 2);
                repeat (n) send_beat(MODE_DATA, BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            else if (kind < 62)
            begin
                send_beat(MODE_MATCH, BYTE_W'($urandom_range(0, 255)));
                send_beat(MODE_DATA, CMD_BYTE_ADDRESS);
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    b = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, BUS_ADDRESS_LO - 1))
                                             : BYTE_W'($urandom_range(BUS_ADDRESS_HI + 1, 255));
                    send_beat(MODE_DATA, b);
                end
                if ($urandom_range(0, 3) != 0)
                    send_beat(MODE_DATA,
                              BYTE_W'($urandom_range(BUS_ADDRESS_LO, BUS_ADDRESS_HI)));
            end
            else if (kind < 92)
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_beat(MODE_SCAN, BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    b = BYTE_W'($urandom_range(0, 255));
                    kind = $urandom_range(0, 3);
                    send_beat(MODE_W'(kind), b, kind != int'(MODE_UNUSED));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
